// ----- hdl/kes_pkg.sv -----
package kes_pkg;

  // Fixed-point word width used inside the solver (32 fractional bits).
  localparam int W = 40;

  // Constants in Q32.
  localparam logic signed [W-1:0] PI_F   = 40'sd13493037705;
  localparam logic signed [W-1:0] HPI_F  = 40'sd6746518852;
  localparam logic signed [W-1:0] E_LIM  = 40'sd17788004978;
  localparam logic signed [W-1:0] K_INIT = 40'sd2608131496;
  localparam logic signed [W-1:0] ONE_F  = 40'sd4294967296;

  localparam int STAGES = 34;
  localparam int DIV_STEPS = 36;

  // Register indexes.
  localparam logic [0:0] REG_TOLERANCE = 1'b0;
  localparam logic [0:0] REG_MAX_ITER  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REDUCE, ST_CORDIC, ST_MUL_SIN, ST_MUL_COS, ST_PREP_DIV, ST_DIV,
    ST_UPDATE, ST_APPLY, ST_DONE
  } state_t;

  // CORDIC arctangent table in Q32, rounded.
  function automatic logic signed [W-1:0] atan_tab(input logic [5:0] i);
    case (i)
      6'd0:  atan_tab = 40'sd3373259426;
      6'd1:  atan_tab = 40'sd1991351318;
      6'd2:  atan_tab = 40'sd1052175346;
      6'd3:  atan_tab = 40'sd534100635;
      6'd4:  atan_tab = 40'sd268086748;
      6'd5:  atan_tab = 40'sd134174063;
      6'd6:  atan_tab = 40'sd67103403;
      6'd7:  atan_tab = 40'sd33553749;
      6'd8:  atan_tab = 40'sd16777131;
      6'd9:  atan_tab = 40'sd8388597;
      6'd10: atan_tab = 40'sd4194303;
      6'd11: atan_tab = 40'sd2097152;
      6'd12: atan_tab = 40'sd1048576;
      6'd13: atan_tab = 40'sd524288;
      6'd14: atan_tab = 40'sd262144;
      6'd15: atan_tab = 40'sd131072;
      6'd16: atan_tab = 40'sd65536;
      6'd17: atan_tab = 40'sd32768;
      6'd18: atan_tab = 40'sd16384;
      6'd19: atan_tab = 40'sd8192;
      6'd20: atan_tab = 40'sd4096;
      6'd21: atan_tab = 40'sd2048;
      6'd22: atan_tab = 40'sd1024;
      6'd23: atan_tab = 40'sd512;
      6'd24: atan_tab = 40'sd256;
      6'd25: atan_tab = 40'sd128;
      6'd26: atan_tab = 40'sd64;
      6'd27: atan_tab = 40'sd32;
      6'd28: atan_tab = 40'sd16;
      6'd29: atan_tab = 40'sd8;
      6'd30: atan_tab = 40'sd4;
      6'd31: atan_tab = 40'sd2;
      6'd32: atan_tab = 40'sd1;
      6'd33: atan_tab = 40'sd1;
      default: atan_tab = '0;
    endcase
  endfunction

endpackage

// ----- hdl/kes_mul.sv -----
// Magnitude multiply of a Q32 eccentricity by a signed Q32 value, truncated
// toward zero; 32 x 34 bits, registered output.
module kes_mul (
  input  logic                               clk,
  input  logic [31:0]                        a,
  input  logic signed [kes_pkg::W-1:0]       b,
  output logic signed [kes_pkg::W-1:0]       p
);
  logic [kes_pkg::W-1:0] mag;
  logic [65:0]           prod;
  logic [kes_pkg::W-1:0] sh;

  // Product of magnitudes, then the sign is applied.
  always_comb begin
    mag  = b[kes_pkg::W-1] ? kes_pkg::W'(-b) : kes_pkg::W'(b);
    prod = {34'd0, a} * {32'd0, mag[33:0]};
    sh   = kes_pkg::W'(prod[65:32]);
  end

  always_ff @(posedge clk) begin
    p <= b[kes_pkg::W-1] ? -$signed(sh) : $signed(sh);
  end
endmodule

// ----- hdl/kepler_equation_solver.sv -----
// Runs N Newton steps (1..64) from the accepted input beat to the result
// beat. Each step is a reduction state, an iterative shift-add CORDIC pass,
// the sine-multiply, cosine-multiply and divider setup states, a restoring
// division (one quotient bit per cycle) and the update, apply and done states.
// One beat is in work at a time: a new beat is taken only after the result is
// emitted, which waits while an earlier result is held. Reset (rst, synchronous)
// returns to idle, drops valid, tolerance=1, max_iterations=32.
module kepler_equation_solver (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [31:0] eccentricity, [66:32] mean_anomaly
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [35:0] eccentric_anomaly, [42:36] step_count
  output logic        m_tuser    // [0] converged
);
  localparam int W = kes_pkg::W;

  logic [15:0] tolerance;
  logic [6:0]  max_iterations;
  kes_pkg::state_t state, state_next;

  logic [31:0]         ecc;
  logic signed [W-1:0] m, e, x, y, z, num, delta;
  logic                flip, neg, conv, sat;
  logic [5:0]          cnt;
  logic [6:0]          steps, limit;
  logic [W-1:0]        rem, den, quo;
  logic signed [W-1:0] mul_b, mul_p;
  logic                wr;
  logic                emit;

  // Configuration port.
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= 16'd1;
      max_iterations <= 7'd32;
    end else if (wr) begin
      if (paddr[2] == kes_pkg::REG_TOLERANCE) tolerance <= pwdata[15:0];
      else max_iterations <= pwdata[6:0];
    end
  end
  always_comb begin
    if (paddr[2] == kes_pkg::REG_TOLERANCE) prdata = {16'd0, tolerance};
    else prdata = {25'd0, max_iterations};
  end

  // Shared multiplier: sine product, then cosine product in the following cycle.
  assign mul_b = (state == kes_pkg::ST_MUL_SIN) ? (flip ? -y : y) : (flip ? -x : x);
  kes_mul u_mul (.clk(clk), .a(ecc), .b(mul_b), .p(mul_p));

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      kes_pkg::ST_IDLE:     if (s_tvalid) state_next = kes_pkg::ST_REDUCE;
      kes_pkg::ST_REDUCE:   state_next = kes_pkg::ST_CORDIC;
      kes_pkg::ST_CORDIC:   if (cnt == 6'(kes_pkg::STAGES - 1)) state_next = kes_pkg::ST_MUL_SIN;
      kes_pkg::ST_MUL_SIN:  state_next = kes_pkg::ST_MUL_COS;
      kes_pkg::ST_MUL_COS:  state_next = kes_pkg::ST_PREP_DIV;
      kes_pkg::ST_PREP_DIV: state_next = kes_pkg::ST_DIV;
      kes_pkg::ST_DIV:      if (cnt == 6'(kes_pkg::DIV_STEPS - 1)) state_next = kes_pkg::ST_UPDATE;
      kes_pkg::ST_UPDATE:   state_next = kes_pkg::ST_APPLY;
      kes_pkg::ST_APPLY:    state_next = kes_pkg::ST_DONE;
      kes_pkg::ST_DONE:     if (conv || steps == limit) begin
                              if (!m_tvalid || m_tready) state_next = kes_pkg::ST_IDLE;
                            end else state_next = kes_pkg::ST_REDUCE;
      default:              state_next = kes_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = (state == kes_pkg::ST_IDLE);
    emit = (state == kes_pkg::ST_DONE) && (conv || steps == limit) &&
           (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kes_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // The result beat stays valid until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  // Datapath.
  logic signed [W-1:0] numx, denx, dsum, dn;
  logic [W-1:0]        nabs, denc;
  always_comb begin
    numx = m + mul_p - e;
    denx = kes_pkg::ONE_F - mul_p;
    denc = (denx < 1) ? W'(1) : W'(denx);
    nabs = num[W-1] ? W'(-num) : W'(num);
    dsum = e + delta;
    dn   = delta[W-1] ? -delta : delta;
  end

  always_ff @(posedge clk) begin
    case (state)
      kes_pkg::ST_IDLE: if (s_tvalid) begin
        ecc   <= s_tdata[31:0];
        m     <= W'($signed(s_tdata[66:32]));
        e     <= W'($signed(s_tdata[66:32]));
        steps <= '0;
        conv  <= 1'b0;
        limit <= (max_iterations == 7'd0) ? 7'd1 :
                 (max_iterations > 7'd64) ? 7'd64 : max_iterations;
      end
      kes_pkg::ST_REDUCE: begin
        x <= kes_pkg::K_INIT;
        y <= '0;
        cnt <= '0;
        if (e > kes_pkg::HPI_F) begin
          z <= e - kes_pkg::PI_F; flip <= 1'b1;
        end else if (e < -kes_pkg::HPI_F) begin
          z <= e + kes_pkg::PI_F; flip <= 1'b1;
        end else begin
          z <= e; flip <= 1'b0;
        end
      end
      kes_pkg::ST_CORDIC: begin
        cnt <= cnt + 6'd1;
        if (!z[W-1]) begin
          x <= x - (y >>> cnt);
          y <= y + (x >>> cnt);
          z <= z - kes_pkg::atan_tab(cnt);
        end else begin
          x <= x + (y >>> cnt);
          y <= y - (x >>> cnt);
          z <= z + kes_pkg::atan_tab(cnt);
        end
      end
      // The sine product is ready here; the cosine product in the next state.
      kes_pkg::ST_MUL_COS: num <= numx;
      kes_pkg::ST_PREP_DIV: begin
        // Saturate when the quotient would reach 16. Otherwise (|num| << 32) >> 36
        // lies below den and seeds the remainder.
        den <= denc;
        neg <= num[W-1];
        sat <= (nabs >= (denc << 4));
        rem <= nabs >> 4;
        quo <= {nabs[3:0], 36'd0};
        cnt <= '0;
      end
      kes_pkg::ST_DIV: begin
        // Restoring division; quo shifts dividend bits out, quotient bits in.
        cnt <= cnt + 6'd1;
        if ({rem, quo[W-1]} >= {1'b0, den}) begin
          rem <= W'({rem, quo[W-1]} - {1'b0, den});
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= W'({rem, quo[W-1]});
          quo <= {quo[W-2:0], 1'b0};
        end
      end
      kes_pkg::ST_UPDATE: begin
        if (sat) delta <= neg ? -$signed((W'(16) << 32) - W'(1))
                              :  $signed((W'(16) << 32) - W'(1));
        else delta <= neg ? -$signed(quo) : $signed(quo);
      end
      kes_pkg::ST_APPLY: begin
        if (dsum > kes_pkg::E_LIM) e <= kes_pkg::E_LIM;
        else if (dsum < -kes_pkg::E_LIM) e <= -kes_pkg::E_LIM;
        else e <= dsum;
        steps <= steps + 7'd1;
        conv  <= (dn <= W'(tolerance));
      end
      kes_pkg::ST_DONE: begin
        if (emit) begin
          m_tdata <= {5'd0, steps, e[35:0]};
          m_tuser <= conv;
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- hdl/kes_checker.sv -----
module kes_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  // Output beat holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("beat dropped");
  // Step count is never zero on a result.
  a_steps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[42:36] != 7'd0) else $error("zero step count");
  // After accepting an item, input stays closed next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted twice");
endmodule

bind kepler_equation_solver kes_checker u_chk (.*);
